@@ rtl/mwec_pkg.sv @@
// Package for the mesh watertight edge check: widths, codes, state types and
// shared constants. No dependencies; imported by mwec_hash and the top level.
`default_nettype none

package mwec_pkg;

  // Default sizing, handed down from the top level
  localparam int EDGE_SLOTS_DEF  = 4096;
  localparam int VERTEX_BITS_DEF = 20;

  // Fixed field widths at the ports
  localparam int VERTEX_FIELD_W = 20;
  localparam int COUNT_W        = 13;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 32;

  // Input kind on tuser
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // Use count codes, saturating
  localparam logic [1:0] USE_ONCE = 2'd1;
  localparam logic [1:0] USE_SAT  = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Fibonacci hashing multiplier
  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

  typedef enum logic [2:0] {
    H_IDLE,
    H_MUL0,
    H_MUL1,
    H_MUL2,
    H_MOD,
    H_REM,
    H_DONE
  } hash_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HSTART,
    S_HASH,
    S_READ,
    S_CHECK,
    S_SCAN,
    S_SCANEND
  } core_state_t;

endpackage

`default_nettype wire

@@ rtl/mwec_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mwec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mwec_hash.sv @@
// Home slot of an edge key: 64-bit wrapping multiply by the hashing constant
// on one shared 32x32 multiplier, then reduction to the table size.
// Depends on mwec_pkg.
`default_nettype none

module mwec_hash import mwec_pkg::*; #(
  parameter int EDGE_SLOTS  = EDGE_SLOTS_DEF,
  parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [2*VERTEX_BITS-1:0]      key,
  output logic                               done,
  output logic      [$clog2(EDGE_SLOTS)-1:0] slot
);

  localparam int  SW      = $clog2(EDGE_SLOTS);
  localparam bit  IS_POW2 = (EDGE_SLOTS & (EDGE_SLOTS - 1)) == 0;
  // Reciprocal 2^(32+SW)/EDGE_SLOTS rounded up; bit 32 is always set here
  localparam logic [63:0] RECIP    = ((64'd1 << (32 + SW)) / 64'(EDGE_SLOTS)) + 64'd1;
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic [31:0] SLOTS_32 = 32'(EDGE_SLOTS);

  hash_state_t state, state_next;
  logic [31:0]   key_lo, key_hi;
  logic [31:0]   acc;
  logic [31:0]   quo;
  logic [SW-1:0] rem;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [64:0]   recip_sum;

  // Shared multiplier: low*low, high*low, low*high, then quotient and remainder
  always_comb begin
    case (state)
      H_MUL1:  begin mul_a = key_hi; mul_b = HASH_MULT[31:0];  end
      H_MUL2:  begin mul_a = key_lo; mul_b = HASH_MULT[63:32]; end
      H_MOD:   begin mul_a = acc;    mul_b = RECIP_LO;         end
      H_REM:   begin mul_a = quo;    mul_b = SLOTS_32;         end
      default: begin mul_a = key_lo; mul_b = HASH_MULT[31:0];  end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Hash times reciprocal, adding the implicit bit 32 of the reciprocal
  assign recip_sum = {1'b0, prod} + {1'b0, acc, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      H_IDLE: if (start) state_next = H_MUL0;
      H_MUL0: state_next = H_MUL1;
      H_MUL1: state_next = H_MUL2;
      H_MUL2: state_next = IS_POW2 ? H_DONE : H_MOD;
      H_MOD:  state_next = H_REM;
      H_REM:  state_next = H_DONE;
      H_DONE: state_next = H_IDLE;
      default: state_next = H_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (start) begin
          key_lo <= 32'(64'(key));
          key_hi <= 32'(64'(key) >> 32);
        end
      end
      H_MUL0: acc <= prod[63:32];
      H_MUL1: acc <= acc + prod[31:0];
      H_MUL2: acc <= acc + prod[31:0];
      H_MOD:  quo <= 32'(recip_sum >> (32 + SW));
      H_REM:  rem <= SW'(acc - prod[31:0]);
      default: ;
    endcase
  end

  assign done = (state == H_DONE);
  assign slot = IS_POW2 ? acc[SW-1:0] : rem;

endmodule

`default_nettype wire

@@ rtl/mesh_watertight_edge_check_core.sv @@
// Top level of the mesh watertight edge check: stream ports, edge sequencer,
// probe and scan control. Depends on mwec_pkg, mwec_hash and mwec_ram.
`default_nettype none

// A triangle transaction is taken and then worked on edge by edge: each of its
// edges is hashed on the shared multiplier (low*low, high*low, low*high
// products, plus a quotient and remainder step for the slot reduction when
// EDGE_SLOTS is not a power of two), then the edge table is read and the entry
// written or updated, with a further read and check for every extra linear
// probe. A finish transaction sweeps the whole table, reading one entry and
// clearing it each cycle, after which the report is held in an output register
// until taken; triangles are accepted again while it waits, a second finish is
// not. After reset the table is cleared before the first transaction is
// accepted. All table state lives in one single-port-read RAM of
// 2*VERTEX_BITS + 3 bits by EDGE_SLOTS entries.
module mesh_watertight_edge_check_core import mwec_pkg::*; #(
  parameter int EDGE_SLOTS  = EDGE_SLOTS_DEF,
  parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [19:0] vertex_one, [39:20] vertex_two, [59:40] vertex_three, [63:60] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [12:0] boundary_count, [25:13] non_manifold_count, [26] is_watertight,
  // [27] table_overflow, [31:28] zero
  output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int SW = $clog2(EDGE_SLOTS);
  localparam int KW = 2 * VERTEX_BITS;
  localparam int MW = KW + 3;
  localparam logic [SW-1:0] LAST_SLOT = SW'(EDGE_SLOTS - 1);

  core_state_t state, state_next;

  logic [VERTEX_BITS-1:0] vert_a, vert_b, vert_c;
  logic [1:0]             edge_idx;
  logic [SW-1:0]          slot, probes, scan_addr, scan_prev, clr_addr;
  logic                   scan_pend;
  logic                   saw_triangle, overflow_seen;
  logic [COUNT_W-1:0]     bnd_cnt, nm_cnt, bnd_next, nm_next;

  logic [VERTEX_BITS-1:0] ep, eq, e_lo, e_hi;
  logic [KW-1:0]          cur_key;
  logic                   hash_start, hash_done;
  logic [SW-1:0]          hash_slot;

  logic          wr_en, rd_en;
  logic [SW-1:0] wr_addr, rd_addr;
  logic [MW-1:0] wr_data, rd_data;

  logic          rd_valid, rd_match;
  logic [1:0]    rd_cnt;
  logic          in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Edge key of the current edge, lower index in the high part
  always_comb begin
    case (edge_idx)
      2'd0:    begin ep = vert_a; eq = vert_b; end
      2'd1:    begin ep = vert_b; eq = vert_c; end
      default: begin ep = vert_c; eq = vert_a; end
    endcase
    e_lo    = (ep < eq) ? ep : eq;
    e_hi    = (ep < eq) ? eq : ep;
    cur_key = {e_lo, e_hi};
  end

  // Read data fields: {valid, use count, key}
  assign rd_valid = rd_data[MW-1];
  assign rd_cnt   = rd_data[KW+1:KW];
  assign rd_match = rd_data[KW-1:0] == cur_key;

  // Scan tallies including the entry arriving this cycle
  always_comb begin
    bnd_next = bnd_cnt;
    nm_next  = nm_cnt;
    if (scan_pend && rd_valid) begin
      if (rd_cnt == USE_ONCE && bnd_cnt != COUNT_MAX) bnd_next = bnd_cnt + 1'b1;
      if (rd_cnt == USE_SAT && nm_cnt != COUNT_MAX)   nm_next  = nm_cnt + 1'b1;
    end
  end

  mwec_hash #(
    .EDGE_SLOTS  (EDGE_SLOTS),
    .VERTEX_BITS (VERTEX_BITS)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (cur_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  mwec_ram #(
    .WIDTH (MW),
    .DEPTH (EDGE_SLOTS)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and memory port control
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    hash_start    = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = slot;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = slot;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == LAST_SLOT) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = !(s_axis_tuser == MODE_FINISH && m_axis_tvalid);
        if (in_acc) state_next = (s_axis_tuser == MODE_FINISH) ? S_SCAN : S_HSTART;
      end
      S_HSTART: begin
        hash_start = 1'b1;
        state_next = S_HASH;
      end
      S_HASH: if (hash_done) state_next = S_READ;
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_valid) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, USE_ONCE, cur_key};
        end else if (rd_match) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, (rd_cnt == USE_SAT) ? USE_SAT : rd_cnt + 2'd1, cur_key};
        end
        if (rd_valid && !rd_match && probes != LAST_SLOT) begin
          state_next = S_READ;
        end else begin
          state_next = (edge_idx == 2'd2) ? S_IDLE : S_HSTART;
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_addr;
        wr_en   = scan_pend;
        wr_addr = scan_prev;
        if (scan_addr == LAST_SLOT) state_next = S_SCANEND;
      end
      S_SCANEND: begin
        wr_en      = scan_pend;
        wr_addr    = scan_prev;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      saw_triangle  <= 1'b0;
      overflow_seen <= 1'b0;
      scan_pend     <= 1'b0;
      bnd_cnt       <= '0;
      nm_cnt        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_acc) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: begin
          if (in_acc) begin
            vert_a    <= VERTEX_BITS'(s_axis_tdata[VERTEX_FIELD_W-1:0]);
            vert_b    <= VERTEX_BITS'(s_axis_tdata[2*VERTEX_FIELD_W-1:VERTEX_FIELD_W]);
            vert_c    <= VERTEX_BITS'(s_axis_tdata[3*VERTEX_FIELD_W-1:2*VERTEX_FIELD_W]);
            edge_idx  <= 2'd0;
            scan_addr <= '0;
            scan_pend <= 1'b0;
            if (s_axis_tuser == MODE_ADD) saw_triangle <= 1'b1;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot   <= hash_slot;
            probes <= '0;
          end
        end
        S_CHECK: begin
          if (rd_valid && !rd_match) begin
            if (probes == LAST_SLOT) begin
              overflow_seen <= 1'b1;
              edge_idx      <= edge_idx + 2'd1;
            end else begin
              probes <= probes + 1'b1;
              slot   <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
            end
          end else begin
            edge_idx <= edge_idx + 2'd1;
          end
        end
        S_SCAN: begin
          bnd_cnt   <= bnd_next;
          nm_cnt    <= nm_next;
          scan_pend <= 1'b1;
          scan_prev <= scan_addr;
          scan_addr <= scan_addr + 1'b1;
        end
        S_SCANEND: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {4'b0, overflow_seen,
                            saw_triangle && bnd_next == '0 && nm_next == '0,
                            nm_next, bnd_next};
          bnd_cnt       <= '0;
          nm_cnt        <= '0;
          scan_pend     <= 1'b0;
          saw_triangle  <= 1'b0;
          overflow_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // The table is never read and written at the same entry in one cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("edge table read and write collide");

  // A finish leaves the sticky flags cleared
  a_flags_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCANEND) |=> (!overflow_seen && !saw_triangle))
    else $error("flags not cleared after report");

  // A report is loaded only when the output register is free
  a_no_report_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCANEND) |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("report overwritten before taken");

  // No transaction accepted while the table is cleared after reset
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_axis_tready)
    else $error("input accepted during table clear");

endmodule

`default_nettype wire
